/* hdl/debounced_button_mode_controller_unit_macros.svh */
// Assertion macros shared by the checker of the button mode controller.
`ifndef DEBOUNCED_BUTTON_MODE_CONTROLLER_UNIT_MACROS_SVH
`define DEBOUNCED_BUTTON_MODE_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define DBMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define DBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dbmc_pkg.sv */
// Types and constants of the debounced button mode controller.
`timescale 1ns / 1ps

package dbmc_pkg;

  localparam int LEVEL_INPUTS = 7;
  localparam int DEBOUNCE_W   = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // button slots
  localparam int BTN_PLAY    = 0;
  localparam int BTN_NEXT    = 1;
  localparam int BTN_PREV    = 2;
  localparam int SWITCH_BASE = 3;
  localparam int NUM_SWITCH  = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MAX   = 3'd7;

  // register reset values
  localparam logic [9:0]  DEBOUNCE_RESET    = 10'd50;
  localparam logic [15:0] STATION_MIN_RESET = 16'd8750;
  localparam logic [15:0] STATION_MAX_RESET = 16'd10790;
  localparam logic [15:0] STATION_RESET     = 16'd8750;
  localparam logic [7:0]  BRIGHT_MIN_RESET  = 8'd0;
  localparam logic [7:0]  BRIGHT_MAX_RESET  = 8'd255;
  localparam logic [6:0]  VOLUME_MIN_RESET  = 7'd0;
  localparam logic [6:0]  VOLUME_MAX_RESET  = 7'd127;

  // step sizes and field limits
  localparam logic [15:0] STATION_STEP  = 16'd20;
  localparam logic [15:0] BRIGHT_STEP   = 16'd16;
  localparam logic [15:0] VOLUME_STEP   = 16'd8;
  localparam logic [15:0] STATION_LIMIT = 16'hFFFF;
  localparam logic [15:0] BRIGHT_LIMIT  = 16'h00FF;
  localparam logic [15:0] VOLUME_LIMIT  = 16'h007F;

  typedef enum logic [1:0] {
    MODE_TRACK   = 2'd0,
    MODE_STATION = 2'd1,
    MODE_BRIGHT  = 2'd2,
    MODE_VOLUME  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_PAUSE = 2'd2
  } play_cmd_e;

  typedef struct packed {
    logic [9:0]  debounce;
    logic [15:0] station_min;
    logic [15:0] station_max;
    logic [7:0]  bright_min;
    logic [7:0]  bright_max;
    logic [6:0]  volume_min;
    logic [6:0]  volume_max;
  } cfg_t;

  typedef struct packed {
    play_cmd_e   play_cmd;
    logic        next_track;
    logic        previous_track;
    logic        station_update;
    logic [15:0] station;
    logic        brightness_update;
    logic [7:0]  brightness;
    logic        volume_update;
    logic [6:0]  volume;
    mode_e       mode;
    logic        mode_changed;
    logic        playing;
  } result_t;

endpackage

/* hdl/dbmc_lane.sv */
// One debounce lane: quiet counter, last raw level and stable level of one button.
`timescale 1ns / 1ps

module dbmc_lane #(
  parameter int COUNT_BITS = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           level_i,
  input  logic [dbmc_pkg::DEBOUNCE_W-1:0] debounce_i,
  output logic                           edge_o
);

  localparam int CMP_W = (COUNT_BITS > dbmc_pkg::DEBOUNCE_W) ? COUNT_BITS
                                                             : dbmc_pkg::DEBOUNCE_W;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  prev_q;
  logic                  stable_q, stable_d;
  logic                  take;

  always_comb begin
    if (level_i != prev_q) begin
      count_d = '0;
    end else if (&count_q) begin
      count_d = count_q;
    end else begin
      count_d = count_q + COUNT_BITS'(1);
    end
    take     = (CMP_W'(count_d) > CMP_W'(debounce_i)) && (level_i != stable_q);
    stable_d = take ? level_i : stable_q;
    edge_o   = take && level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      prev_q   <= 1'b0;
      stable_q <= 1'b0;
    end else if (en_i) begin
      count_q  <= count_d;
      prev_q   <= level_i;
      stable_q <= stable_d;
    end
  end

endmodule

/* hdl/dbmc_merge.sv */
// Merge stage: play flag, mode, station and brightness state, and the result of one tick.
`timescale 1ns / 1ps

module dbmc_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [dbmc_pkg::LEVEL_INPUTS-1:0]   edges_i,
  input  dbmc_pkg::cfg_t                      cfg_i,
  input  logic [6:0]                          host_volume_i,
  input  logic                                status_valid_i,
  input  logic                                status_playing_i,
  output dbmc_pkg::result_t                   result_o
);

  dbmc_pkg::mode_e mode_q, mode_d;
  logic            playing_q, playing_d;
  logic [15:0]     station_q, station_d;
  logic [7:0]      bright_q, bright_d;

  logic            e_next, e_prev, e_any;
  logic            play_base;
  logic [15:0]     st_up, st_dn;
  logic [15:0]     br_up, br_dn;
  logic [15:0]     vo_up, vo_dn;

  function automatic logic [15:0] step_up(input logic [15:0] v, input logic [15:0] bound,
                                          input logic [15:0] step, input logic [15:0] limit);
    logic [16:0] sum;
    sum = {1'b0, v} + {1'b0, step};
    if (v < bound) begin
      return (sum > {1'b0, limit}) ? limit : sum[15:0];
    end
    return v;
  endfunction

  function automatic logic [15:0] step_down(input logic [15:0] v, input logic [15:0] bound,
                                            input logic [15:0] step);
    if (v > bound) begin
      return (v > step) ? (v - step) : 16'd0;
    end
    return v;
  endfunction

  always_comb begin
    e_next = edges_i[dbmc_pkg::BTN_NEXT];
    e_prev = edges_i[dbmc_pkg::BTN_PREV];
    e_any  = e_next || e_prev;

    // next first, previous works on what next left
    st_up = e_next ? step_up(station_q, cfg_i.station_max, dbmc_pkg::STATION_STEP,
                             dbmc_pkg::STATION_LIMIT) : station_q;
    st_dn = e_prev ? step_down(st_up, cfg_i.station_min, dbmc_pkg::STATION_STEP) : st_up;
    br_up = e_next ? step_up(16'(bright_q), 16'(cfg_i.bright_max), dbmc_pkg::BRIGHT_STEP,
                             dbmc_pkg::BRIGHT_LIMIT) : 16'(bright_q);
    br_dn = e_prev ? step_down(br_up, 16'(cfg_i.bright_min), dbmc_pkg::BRIGHT_STEP) : br_up;
    vo_up = e_next ? step_up(16'(host_volume_i), 16'(cfg_i.volume_max), dbmc_pkg::VOLUME_STEP,
                             dbmc_pkg::VOLUME_LIMIT) : 16'(host_volume_i);
    vo_dn = e_prev ? step_down(vo_up, 16'(cfg_i.volume_min), dbmc_pkg::VOLUME_STEP) : vo_up;

    result_o = '0;

    // status event lands before the play button
    play_base = status_valid_i ? status_playing_i : playing_q;
    playing_d = play_base;
    result_o.play_cmd = dbmc_pkg::CMD_NONE;
    if (edges_i[dbmc_pkg::BTN_PLAY]) begin
      playing_d = !play_base;
      result_o.play_cmd = playing_d ? dbmc_pkg::CMD_PLAY : dbmc_pkg::CMD_PAUSE;
    end

    station_d = station_q;
    bright_d  = bright_q;
    case (mode_q)
      dbmc_pkg::MODE_TRACK: begin
        result_o.next_track     = e_next;
        result_o.previous_track = e_prev;
      end
      dbmc_pkg::MODE_STATION: begin
        station_d = st_dn;
        result_o.station_update = e_any;
      end
      dbmc_pkg::MODE_BRIGHT: begin
        bright_d = br_dn[7:0];
        result_o.brightness_update = e_any;
      end
      dbmc_pkg::MODE_VOLUME: begin
        result_o.volume_update = e_any;
        result_o.volume        = e_any ? vo_dn[6:0] : 7'd0;
      end
      default: begin
      end
    endcase

    // highest numbered switch wins
    mode_d = mode_q;
    result_o.mode_changed = 1'b0;
    for (int k = 0; k < dbmc_pkg::NUM_SWITCH; k++) begin
      if (edges_i[dbmc_pkg::SWITCH_BASE + k]) begin
        mode_d = dbmc_pkg::mode_e'(2'(k));
        result_o.mode_changed = 1'b1;
      end
    end

    result_o.station    = station_d;
    result_o.brightness = bright_d;
    result_o.mode       = mode_d;
    result_o.playing    = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= dbmc_pkg::MODE_TRACK;
      playing_q <= 1'b1;
      station_q <= dbmc_pkg::STATION_RESET;
      bright_q  <= dbmc_pkg::BRIGHT_MAX_RESET;
    end else if (en_i) begin
      mode_q    <= mode_d;
      playing_q <= playing_d;
      station_q <= station_d;
      bright_q  <= bright_d;
    end
  end

endmodule

/* hdl/debounced_button_mode_controller_unit.sv */
// Top level of the debounced button mode controller: lanes, merge stage, output buffer.
`timescale 1ns / 1ps

// One request is one 1 ms tick with seven raw button and switch levels, the host
// volume and an optional play-status event; it yields exactly one result. Every
// request is finished in the cycle it is taken (a row of per-button debounce lanes
// feeds one merge stage), so a request can be taken every cycle while in_stall_o
// is low, and the result is registered in a two-entry output buffer. in_stall_o
// rises only when both buffer entries are held by a stalled output. Configuration
// writes are taken every cycle (cfg_ready_o is always high) and belong in idle
// periods. The station starts at the reset value of initial_station; a later write
// to that register has no effect on a running block.
module debounced_button_mode_controller_unit #(
  parameter int BUTTON_COUNT = 7,
  parameter int COUNT_BITS   = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        play_button_i,
  input  logic        next_button_i,
  input  logic        prev_button_i,
  input  logic        playback_switch_i,
  input  logic        station_switch_i,
  input  logic        brightness_switch_i,
  input  logic        volume_switch_i,
  input  logic [6:0]  host_volume_i,
  input  logic        status_valid_i,
  input  logic        status_playing_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  play_cmd_o,
  output logic        next_track_o,
  output logic        previous_track_o,
  output logic        station_update_o,
  output logic [15:0] station_o,
  output logic        brightness_update_o,
  output logic [7:0]  brightness_o,
  output logic        volume_update_o,
  output logic [6:0]  volume_o,
  output logic [1:0]  mode_o,
  output logic        mode_changed_o,
  output logic        playing_o
);

  localparam int NUM_LANES = (BUTTON_COUNT < dbmc_pkg::LEVEL_INPUTS) ? BUTTON_COUNT
                                                                     : dbmc_pkg::LEVEL_INPUTS;

  dbmc_pkg::cfg_t    cfg_q;
  dbmc_pkg::result_t result;
  dbmc_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              accept;
  logic              out_free;
  logic [dbmc_pkg::LEVEL_INPUTS-1:0] levels;
  logic [dbmc_pkg::LEVEL_INPUTS-1:0] edges;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce    <= dbmc_pkg::DEBOUNCE_RESET;
      cfg_q.station_min <= dbmc_pkg::STATION_MIN_RESET;
      cfg_q.station_max <= dbmc_pkg::STATION_MAX_RESET;
      cfg_q.bright_min  <= dbmc_pkg::BRIGHT_MIN_RESET;
      cfg_q.bright_max  <= dbmc_pkg::BRIGHT_MAX_RESET;
      cfg_q.volume_min  <= dbmc_pkg::VOLUME_MIN_RESET;
      cfg_q.volume_max  <= dbmc_pkg::VOLUME_MAX_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbmc_pkg::REG_DEBOUNCE:     cfg_q.debounce    <= cfg_data_i[9:0];
        dbmc_pkg::REG_STATION_MIN:  cfg_q.station_min <= cfg_data_i;
        dbmc_pkg::REG_STATION_MAX:  cfg_q.station_max <= cfg_data_i;
        dbmc_pkg::REG_INIT_STATION: begin
          // only matters at reset, which loads its reset value
        end
        dbmc_pkg::REG_BRIGHT_MIN:   cfg_q.bright_min  <= cfg_data_i[7:0];
        dbmc_pkg::REG_BRIGHT_MAX:   cfg_q.bright_max  <= cfg_data_i[7:0];
        dbmc_pkg::REG_VOLUME_MIN:   cfg_q.volume_min  <= cfg_data_i[6:0];
        dbmc_pkg::REG_VOLUME_MAX:   cfg_q.volume_max  <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  assign levels = {volume_switch_i, brightness_switch_i, station_switch_i, playback_switch_i,
                   prev_button_i, next_button_i, play_button_i};

  for (genvar g = 0; g < dbmc_pkg::LEVEL_INPUTS; g++) begin : g_lane
    if (g < NUM_LANES) begin : g_on
      dbmc_lane #(
        .COUNT_BITS(COUNT_BITS)
      ) u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (accept),
        .level_i   (levels[g]),
        .debounce_i(cfg_q.debounce),
        .edge_o    (edges[g])
      );
    end else begin : g_off
      assign edges[g] = 1'b0;
    end
  end

  dbmc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (accept),
    .edges_i         (edges),
    .cfg_i           (cfg_q),
    .host_volume_i   (host_volume_i),
    .status_valid_i  (status_valid_i),
    .status_playing_i(status_playing_i),
    .result_o        (result)
  );

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign play_cmd_o          = out_q.play_cmd;
  assign next_track_o        = out_q.next_track;
  assign previous_track_o    = out_q.previous_track;
  assign station_update_o    = out_q.station_update;
  assign station_o           = out_q.station;
  assign brightness_update_o = out_q.brightness_update;
  assign brightness_o        = out_q.brightness;
  assign volume_update_o     = out_q.volume_update;
  assign volume_o            = out_q.volume;
  assign mode_o              = out_q.mode;
  assign mode_changed_o      = out_q.mode_changed;
  assign playing_o           = out_q.playing;

endmodule

/* hdl/dbmc_checker.sv */
// Port-level checker of the button mode controller and its bind statement.
`timescale 1ns / 1ps
`include "debounced_button_mode_controller_unit_macros.svh"

module dbmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  play_cmd_o,
  input logic        next_track_o,
  input logic        previous_track_o,
  input logic        station_update_o,
  input logic [15:0] station_o,
  input logic        brightness_update_o,
  input logic        volume_update_o,
  input logic [6:0]  volume_o,
  input logic        playing_o
);

  `DBMC_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(station_o) && $stable(volume_o), "stalled result changed")

  `DBMC_ASSERT_NOW(a_volume_idle_zero, out_valid_o && !volume_update_o, volume_o == 7'd0, "volume nonzero without update")

  `DBMC_ASSERT_NOW(a_cmd_matches_flag, out_valid_o && (play_cmd_o == dbmc_pkg::CMD_PLAY || play_cmd_o == dbmc_pkg::CMD_PAUSE), playing_o == (play_cmd_o == dbmc_pkg::CMD_PLAY), "play command disagrees with playing flag")

  `DBMC_ASSERT_NOW(a_one_mode_action, out_valid_o, $countones({next_track_o || previous_track_o, station_update_o, brightness_update_o, volume_update_o}) <= 1, "step actions of two modes in one result")

endmodule

bind debounced_button_mode_controller_unit dbmc_checker u_dbmc_checker (.*);
